// ===== hw/rtl/hlp_pkg.sv =====
`timescale 1ns / 1ps

package hlp_pkg;

    // Character codes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Header value begins this many bytes after the colon
    localparam int VALUE_SKIP = 2;

    localparam logic [4:0] KEY_TE_LEN      = 5'd17;
    localparam logic [4:0] KEY_CL_LEN      = 5'd14;
    localparam logic [4:0] KEY_NO_MATCH    = 5'd31;
    localparam logic [3:0] VAL_CHUNKED_LEN = 4'd7;
    localparam logic [3:0] VAL_NO_MATCH    = 4'd15;

    typedef enum logic [1:0] {
        PH_HEADLINE = 2'd0,
        PH_HEADERS  = 2'd1,
        PH_DONE     = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        LK_HEADLINE    = 3'd0,
        LK_HDR_COLON   = 3'd1,
        LK_HDR_NOCOLON = 3'd2,
        LK_END_OF_HEAD = 3'd3,
        LK_MALFORMED   = 3'd4
    } t_line_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } t_in_item;

    typedef struct packed {
        t_line_kind  line_kind;
        logic [15:0] line_start;
        logic [15:0] line_length;
        logic [15:0] first_length;
        logic [15:0] second_start;
        logic [15:0] second_length;
        logic [15:0] third_start;
        logic [15:0] third_length;
        logic [15:0] status_code;
        logic        chunked_flag;
        logic [31:0] body_length;
    } t_record;

    function automatic logic [7:0] to_lower(logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A) begin
            r = b + 8'd32;
        end
        return r;
    endfunction

    function automatic logic [7:0] te_char(logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = "t";
            5'd1:    c = "r";
            5'd2:    c = "a";
            5'd3:    c = "n";
            5'd4:    c = "s";
            5'd5:    c = "f";
            5'd6:    c = "e";
            5'd7:    c = "r";
            5'd8:    c = "-";
            5'd9:    c = "e";
            5'd10:   c = "n";
            5'd11:   c = "c";
            5'd12:   c = "o";
            5'd13:   c = "d";
            5'd14:   c = "i";
            5'd15:   c = "n";
            5'd16:   c = "g";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] cl_char(logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = "c";
            5'd1:    c = "o";
            5'd2:    c = "n";
            5'd3:    c = "t";
            5'd4:    c = "e";
            5'd5:    c = "n";
            5'd6:    c = "t";
            5'd7:    c = "-";
            5'd8:    c = "l";
            5'd9:    c = "e";
            5'd10:   c = "n";
            5'd11:   c = "g";
            5'd12:   c = "t";
            5'd13:   c = "h";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] chunked_char(logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "c";
            4'd1:    c = "h";
            4'd2:    c = "u";
            4'd3:    c = "n";
            4'd4:    c = "k";
            4'd5:    c = "e";
            4'd6:    c = "d";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/hlp_intf.sv =====
`timescale 1ns / 1ps

interface hlp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface hlp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  line_kind;
    logic [15:0] line_start;
    logic [15:0] line_length;
    logic [15:0] first_length;
    logic [15:0] second_start;
    logic [15:0] second_length;
    logic [15:0] third_start;
    logic [15:0] third_length;
    logic [15:0] status_code;
    logic        chunked_flag;
    logic [31:0] body_length;

    modport source (
        output valid, output line_kind, output line_start, output line_length,
        output first_length, output second_start, output second_length,
        output third_start, output third_length, output status_code,
        output chunked_flag, output body_length, input ready
    );
    modport sink (
        input valid, input line_kind, input line_start, input line_length,
        input first_length, input second_start, input second_length,
        input third_start, input third_length, input status_code,
        input chunked_flag, input body_length, output ready
    );
endinterface

// ===== hw/rtl/hlp_in_reg.sv =====
`timescale 1ns / 1ps

module hlp_in_reg
    import hlp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_ready,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== hw/rtl/hlp_parser.sv =====
`timescale 1ns / 1ps

module hlp_parser
    import hlp_pkg::*;
#(
    parameter int MAX_HEAD_BYTES = 65536
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_in_item i_item,
    input  logic     i_response_mode,
    output logic     o_rec_valid,
    output t_record  o_rec
);

    localparam int OW = $clog2(MAX_HEAD_BYTES + 1);
    localparam logic [OW-1:0] MAX_OFF = OW'(MAX_HEAD_BYTES);

    // Parse state
    t_phase        r_phase, c_phase, n_phase;
    logic [OW-1:0] r_off, c_off, n_off;
    logic [OW-1:0] r_sol, c_sol, n_sol;
    logic          r_saw_cr, c_saw_cr, n_saw_cr;
    logic [1:0]    r_dcnt, c_dcnt, n_dcnt;
    logic [OW-1:0] r_tm0, c_tm0, n_tm0;
    logic [OW-1:0] r_tm1, c_tm1, n_tm1;
    logic [OW-1:0] r_tm2, c_tm2, n_tm2;
    logic [4:0]    r_km0, c_km0, n_km0;
    logic [4:0]    r_km1, c_km1, n_km1;
    logic [3:0]    r_vm, c_vm, n_vm;
    logic [31:0]   r_acc, c_acc, n_acc;
    logic          r_dend, c_dend, n_dend;
    logic          r_chk, c_chk, n_chk;
    logic [31:0]   r_lenr, c_lenr, n_lenr;

    logic [7:0]    w_b;
    logic [7:0]    w_lb;
    logic          w_first;
    logic          w_live, w_over, w_run;
    logic          w_is_cr, w_is_lf, w_is_digit;
    logic [3:0]    w_digit;
    logic [OW-1:0] w_crpos;
    logic [OW-1:0] w_len;
    logic [OW-1:0] w_over_len;
    logic [35:0]   w_acc_x10;
    logic [31:0]   w_sat16, w_sat32;
    logic [OW+1:0] w_third_diff;
    logic [OW+1:0] w_value_diff;
    logic [OW:0]   w_path_start;
    logic [OW:0]   w_value_start;

    // A first byte clears the message before it is parsed
    assign w_first  = i_step && i_item.first_byte;
    assign c_phase  = w_first ? PH_HEADLINE : r_phase;
    assign c_off    = w_first ? '0 : r_off;
    assign c_sol    = w_first ? '0 : r_sol;
    assign c_saw_cr = w_first ? 1'b0 : r_saw_cr;
    assign c_dcnt   = w_first ? 2'd0 : r_dcnt;
    assign c_tm0    = w_first ? '0 : r_tm0;
    assign c_tm1    = w_first ? '0 : r_tm1;
    assign c_tm2    = w_first ? '0 : r_tm2;
    assign c_km0    = w_first ? 5'd0 : r_km0;
    assign c_km1    = w_first ? 5'd0 : r_km1;
    assign c_vm     = w_first ? 4'd0 : r_vm;
    assign c_acc    = w_first ? 32'd0 : r_acc;
    assign c_dend   = w_first ? 1'b0 : r_dend;
    assign c_chk    = w_first ? 1'b0 : r_chk;
    assign c_lenr   = w_first ? 32'd0 : r_lenr;

    assign w_b        = i_item.data_byte;
    assign w_lb       = to_lower(w_b);
    assign w_live     = i_step && (c_phase != PH_DONE);
    assign w_over     = w_live && (c_off >= MAX_OFF);
    assign w_run      = w_live && !w_over;
    assign w_is_cr    = (w_b == CH_CR);
    assign w_is_lf    = (w_b == CH_LF);
    assign w_is_digit = (w_b >= CH_ZERO) && (w_b <= CH_NINE);
    assign w_digit    = 4'(w_b - CH_ZERO);

    assign w_crpos    = c_off - OW'(1);
    assign w_len      = w_crpos - c_sol;
    assign w_over_len = c_off - c_sol;

    assign w_acc_x10 = {1'b0, c_acc, 3'b000} + {3'b000, c_acc, 1'b0} + {32'd0, w_digit};
    assign w_sat16   = (|w_acc_x10[35:16]) ? 32'h0000_FFFF : {16'd0, w_acc_x10[15:0]};
    assign w_sat32   = (|w_acc_x10[35:32]) ? 32'hFFFF_FFFF : w_acc_x10[31:0];

    assign w_third_diff  = {2'b00, w_crpos} - {2'b00, c_tm2};
    assign w_value_diff  = {2'b00, w_len} - {2'b00, c_tm0} - (OW+2)'(VALUE_SKIP);
    assign w_path_start  = {1'b0, c_sol} + {1'b0, c_tm0} + (OW+1)'(1);
    assign w_value_start = {1'b0, c_sol} + {1'b0, c_tm0} + (OW+1)'(VALUE_SKIP);

    // Next phase
    always_comb begin
        n_phase = c_phase;
        if (w_over) begin
            n_phase = PH_DONE;
        end else if (w_run && c_saw_cr) begin
            if (!w_is_lf) begin
                n_phase = PH_DONE;
            end else begin
                unique case (c_phase)
                    PH_HEADLINE: n_phase = PH_HEADERS;
                    PH_HEADERS:  n_phase = (w_len == '0) ? PH_DONE : PH_HEADERS;
                    default:     n_phase = c_phase;
                endcase
            end
        end
    end

    // Line datapath: offsets, delimiters, matchers, accumulator
    always_comb begin
        n_off    = c_off;
        n_sol    = c_sol;
        n_saw_cr = c_saw_cr;
        n_dcnt   = c_dcnt;
        n_tm0    = c_tm0;
        n_tm1    = c_tm1;
        n_tm2    = c_tm2;
        n_km0    = c_km0;
        n_km1    = c_km1;
        n_vm     = c_vm;
        n_acc    = c_acc;
        n_dend   = c_dend;
        n_chk    = c_chk;
        n_lenr   = c_lenr;
        if (w_run) begin
            n_off = c_off + OW'(1);
            if (c_saw_cr) begin
                n_saw_cr = 1'b0;
                if (w_is_lf) begin
                    // Commit a recognized header before the line is cleared
                    if (c_phase == PH_HEADERS && w_len != '0 && c_dcnt != 2'd0) begin
                        if (c_km0 == KEY_TE_LEN) begin
                            n_chk = (c_vm == VAL_CHUNKED_LEN);
                        end
                        if (c_km1 == KEY_CL_LEN) begin
                            n_lenr = c_acc;
                        end
                    end
                    n_sol  = c_off + OW'(1);
                    n_dcnt = 2'd0;
                    n_tm0  = '0;
                    n_tm1  = '0;
                    n_tm2  = '0;
                    n_km0  = 5'd0;
                    n_km1  = 5'd0;
                    n_vm   = 4'd0;
                    n_acc  = 32'd0;
                    n_dend = 1'b0;
                end
            end else if (w_is_cr) begin
                n_saw_cr = 1'b1;
                // A CR right after the status digits opens an empty message
                if (c_phase == PH_HEADLINE && i_response_mode && c_dcnt == 2'd1) begin
                    n_tm2  = c_off + OW'(1);
                    n_dcnt = 2'd2;
                end
            end else if (c_phase == PH_HEADLINE) begin
                if (!i_response_mode) begin
                    if (w_b == CH_SPACE) begin
                        if (c_dcnt == 2'd0) begin
                            n_tm0  = c_off - c_sol;
                            n_dcnt = 2'd1;
                        end else if (c_dcnt == 2'd1) begin
                            n_tm1  = c_off - c_sol - c_tm0 - OW'(1);
                            n_tm2  = c_off + OW'(1);
                            n_dcnt = 2'd2;
                        end
                    end
                end else begin
                    if (c_dcnt == 2'd0) begin
                        if (w_b == CH_SPACE) begin
                            n_tm0  = c_off - c_sol;
                            n_acc  = 32'd0;
                            n_dcnt = 2'd1;
                        end
                    end else if (c_dcnt == 2'd1) begin
                        if (w_is_digit) begin
                            n_acc = w_sat16;
                        end else begin
                            n_tm2  = c_off + OW'(1);
                            n_dcnt = 2'd2;
                        end
                    end
                end
            end else begin
                if (c_dcnt == 2'd0) begin
                    if (w_b == CH_COLON) begin
                        n_tm0  = c_off - c_sol;
                        n_dcnt = 2'd1;
                    end else begin
                        n_km0 = (c_km0 < KEY_TE_LEN && w_lb == te_char(c_km0))
                              ? c_km0 + 5'd1 : KEY_NO_MATCH;
                        n_km1 = (c_km1 < KEY_CL_LEN && w_lb == cl_char(c_km1))
                              ? c_km1 + 5'd1 : KEY_NO_MATCH;
                    end
                end else if (c_dcnt == 2'd1) begin
                    // Skip the byte right after the colon
                    n_dcnt = 2'd2;
                end else begin
                    n_vm = (c_vm < VAL_CHUNKED_LEN && w_lb == chunked_char(c_vm))
                         ? c_vm + 4'd1 : VAL_NO_MATCH;
                    if (!c_dend && w_is_digit) begin
                        n_acc = w_sat32;
                    end else begin
                        n_dend = 1'b1;
                    end
                end
            end
        end
    end

    // Record
    always_comb begin
        o_rec_valid = w_over || (w_run && c_saw_cr);
        o_rec       = '0;
        o_rec.line_kind    = LK_MALFORMED;
        o_rec.line_start   = 16'(c_sol);
        o_rec.line_length  = 16'(w_len);
        o_rec.chunked_flag = n_chk;
        o_rec.body_length  = n_lenr;
        if (w_over) begin
            o_rec.line_length = 16'(w_over_len);
        end else if (c_saw_cr && w_is_lf) begin
            if (c_phase == PH_HEADLINE) begin
                o_rec.line_kind = LK_HEADLINE;
                if (!i_response_mode) begin
                    if (c_dcnt != 2'd0) begin
                        o_rec.first_length = 16'(c_tm0);
                        o_rec.second_start = 16'(w_path_start);
                    end
                    if (c_dcnt == 2'd2) begin
                        o_rec.second_length = 16'(c_tm1);
                        o_rec.third_start   = 16'(c_tm2);
                        o_rec.third_length  = w_third_diff[OW+1] ? 16'd0 : 16'(w_third_diff);
                    end
                end else if (c_dcnt != 2'd0) begin
                    o_rec.first_length = 16'(c_tm0);
                    o_rec.third_start  = 16'(c_tm2);
                    o_rec.third_length = w_third_diff[OW+1] ? 16'd0 : 16'(w_third_diff);
                    o_rec.status_code  = c_acc[15:0];
                end
            end else if (w_len == '0) begin
                o_rec.line_kind = LK_END_OF_HEAD;
            end else if (c_dcnt == 2'd0) begin
                o_rec.line_kind = LK_HDR_NOCOLON;
            end else begin
                o_rec.line_kind     = LK_HDR_COLON;
                o_rec.first_length  = 16'(c_tm0);
                o_rec.second_start  = 16'(w_value_start);
                o_rec.second_length = w_value_diff[OW+1] ? 16'd0 : 16'(w_value_diff);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADLINE;
            r_off    <= '0;
            r_sol    <= '0;
            r_saw_cr <= 1'b0;
            r_dcnt   <= 2'd0;
            r_tm0    <= '0;
            r_tm1    <= '0;
            r_tm2    <= '0;
            r_km0    <= 5'd0;
            r_km1    <= 5'd0;
            r_vm     <= 4'd0;
            r_acc    <= 32'd0;
            r_dend   <= 1'b0;
            r_chk    <= 1'b0;
            r_lenr   <= 32'd0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_off    <= n_off;
            r_sol    <= n_sol;
            r_saw_cr <= n_saw_cr;
            r_dcnt   <= n_dcnt;
            r_tm0    <= n_tm0;
            r_tm1    <= n_tm1;
            r_tm2    <= n_tm2;
            r_km0    <= n_km0;
            r_km1    <= n_km1;
            r_vm     <= n_vm;
            r_acc    <= n_acc;
            r_dend   <= n_dend;
            r_chk    <= n_chk;
            r_lenr   <= n_lenr;
        end
    end

endmodule

// ===== hw/rtl/hlp_out_reg.sv =====
`timescale 1ns / 1ps

module hlp_out_reg
    import hlp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_record i_rec,
    output logic    o_room,
    output logic    o_valid,
    output t_record o_rec,
    input  logic    i_ready
);

    logic    r_valid;
    t_record r_rec;

    // Free when empty or when the held record leaves this cycle
    assign o_room  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_rec   = r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_room) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_room && i_load) begin
            r_rec <= i_rec;
        end
    end

endmodule

// ===== hw/rtl/http_head_line_parser_core.sv =====
`timescale 1ns / 1ps

// HTTP message head parser. Bytes of a message head enter on i_in, one per
// transfer, and one record leaves on o_out for every CR LF that closes a line:
// the headline (request method/path/version or response version/status/message),
// each header line (key length and value span), the blank line that ends the
// head, or a malformed record for a lone CR or a head longer than
// MAX_HEAD_BYTES, after which bytes are dropped until one with first_byte set.
// The keys transfer-encoding and content-length are matched without regard to
// case and update the chunked flag and body length carried on every record.
// Throughput is one byte per clock while the result register has room. A byte
// gets its parse step while it sits in the input register, and the record for
// the LF that closes a line is loaded into the result register at that step
// and offered on o_out from there. The input stalls only while the result
// register holds a record that the receiver has not yet taken. Write i_cfg_data
// (response mode) only while no bytes are in flight.

module http_head_line_parser_core
    import hlp_pkg::*;
#(
    parameter int MAX_HEAD_BYTES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    hlp_in_if.sink      i_in,
    hlp_out_if.source   o_out
);

    logic     r_response_mode;

    t_in_item w_in_item;
    t_in_item w_held_item;
    logic     w_held_valid;
    logic     w_step;
    logic     w_room;
    logic     w_rec_valid;
    t_record  w_rec;
    t_record  w_out_rec;

    // Response mode register; 0 selects request headlines
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_response_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_response_mode <= i_cfg_data;
        end
    end

    assign w_in_item.data_byte  = i_in.data_byte;
    assign w_in_item.first_byte = i_in.first_byte;

    // Register the incoming byte to cut the ready path from the parser
    hlp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_item  (w_in_item),
        .o_ready (i_in.ready),
        .i_take  (w_step),
        .o_valid (w_held_valid),
        .o_item  (w_held_item)
    );

    // Advance the parser only when the result register can take a record
    assign w_step = w_held_valid && w_room;

    hlp_parser #(
        .MAX_HEAD_BYTES (MAX_HEAD_BYTES)
    ) u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_step),
        .i_item          (w_held_item),
        .i_response_mode (r_response_mode),
        .o_rec_valid     (w_rec_valid),
        .o_rec           (w_rec)
    );

    // Result register: a finished record waits here while parsing goes on
    hlp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_step && w_rec_valid),
        .i_rec   (w_rec),
        .o_room  (w_room),
        .o_valid (o_out.valid),
        .o_rec   (w_out_rec),
        .i_ready (o_out.ready)
    );

    assign o_out.line_kind     = w_out_rec.line_kind;
    assign o_out.line_start    = w_out_rec.line_start;
    assign o_out.line_length   = w_out_rec.line_length;
    assign o_out.first_length  = w_out_rec.first_length;
    assign o_out.second_start  = w_out_rec.second_start;
    assign o_out.second_length = w_out_rec.second_length;
    assign o_out.third_start   = w_out_rec.third_start;
    assign o_out.third_length  = w_out_rec.third_length;
    assign o_out.status_code   = w_out_rec.status_code;
    assign o_out.chunked_flag  = w_out_rec.chunked_flag;
    assign o_out.body_length   = w_out_rec.body_length;

endmodule
